// ===== rtl/ffbp_pkg.sv =====
package ffbp_pkg;

   localparam int MAX_BINS_DEFAULT = 256;

   localparam int WEIGHT_W   = 16;
   localparam int INDEX_OUT_W = 8;
   localparam int USED_OUT_W  = 9;
   localparam int ERR_W       = 2;

   localparam logic [WEIGHT_W-1:0] CAPACITY_RESET = 16'd1000;

   localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_TOO_HEAVY  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NO_BIN     = 2'd2;

endpackage

// ===== rtl/ffbp_ram.sv =====
module ffbp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/first_fit_bin_packer.sv =====
// an accepted word is placed by one bin-room memory read per cycle in index order, stopping
// at the first bin that fits; a weight above the capacity skips the scan. one word at a
// time: the next word can be taken the cycle after its result enters the output register,
// and a stalled result holds the sequencer. synchronous active-high reset clears the bin
// count, the sequencer and the output valid and sets the capacity to 1000; bin rooms need
// no reset.
module first_fit_bin_packer
   import ffbp_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [WEIGHT_W-1:0]    req_item_weight,
   input  logic                   req_last_item,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [INDEX_OUT_W-1:0] rsp_bin_index,
   output logic [USED_OUT_W-1:0]  rsp_bins_used,
   output logic [ERR_W-1:0]       rsp_placement_error,
   output logic                   rsp_run_done,

   input  logic                   csr_wr_en,
   input  logic [WEIGHT_W-1:0]    csr_wr_data
);

   localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CNT_W = $clog2(MAX_BINS + 1);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_BINS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [WEIGHT_W-1:0]  capacity_ff;
   logic [CNT_W-1:0]     open_ff, open_in;
   logic [WEIGHT_W-1:0]  weight_ff, weight_in;
   logic                 last_ff, last_in;
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                 data_vld_ff, data_vld_in;
   logic [IDX_W-1:0]     chosen_ff, chosen_in;
   logic [ERR_W-1:0]     err_ff, err_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_OUT_W-1:0] rsp_index_ff, rsp_index_in;
   logic [USED_OUT_W-1:0]  rsp_used_ff, rsp_used_in;
   logic [ERR_W-1:0]       rsp_err_ff, rsp_err_in;
   logic                   rsp_done_ff, rsp_done_in;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [WEIGHT_W-1:0]  ram_wr_data;
   logic                 ram_rd_en;
   logic [WEIGHT_W-1:0]  ram_rd_data;

   logic                 req_take;
   logic                 out_free;
   logic                 fit;
   logic                 scan_end;

   ffbp_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (MAX_BINS)
   ) u_room (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // one compare per cycle against the word read the cycle before
   assign fit      = data_vld_ff && (ram_rd_data >= weight_ff);
   assign scan_end = data_vld_ff ? ((CNT_W'(cmp_idx_ff) + 1'b1) == open_ff)
                                 : (rd_idx_ff == open_ff);

   always_comb begin
      state_in    = state_ff;
      open_in     = open_ff;
      weight_in   = weight_ff;
      last_in     = last_ff;
      rd_idx_in   = rd_idx_ff;
      cmp_idx_in  = cmp_idx_ff;
      data_vld_in = 1'b0;
      chosen_in   = chosen_ff;
      err_in      = err_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cmp_idx_ff;
      ram_wr_data = ram_rd_data - weight_ff;
      ram_rd_en   = 1'b0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_used_in  = rsp_used_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_done_in  = rsp_done_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               weight_in = req_item_weight;
               last_in   = req_last_item;
               rd_idx_in = '0;
               chosen_in = '0;
               if (req_item_weight > capacity_ff) begin
                  err_in   = ERR_TOO_HEAVY;
                  state_in = ST_DONE;
               end else begin
                  err_in   = ERR_NONE;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (fit) begin
               ram_wr_en = 1'b1;
               chosen_in = cmp_idx_ff;
               state_in  = ST_DONE;
            end else if (scan_end) begin
               if (open_ff < MAX_COUNT) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = open_ff[IDX_W-1:0];
                  ram_wr_data = capacity_ff - weight_ff;
                  chosen_in   = open_ff[IDX_W-1:0];
                  open_in     = open_ff + 1'b1;
               end else begin
                  err_in = ERR_NO_BIN;
               end
               state_in = ST_DONE;
            end else if (rd_idx_ff < open_ff) begin
               ram_rd_en   = 1'b1;
               data_vld_in = 1'b1;
               cmp_idx_in  = rd_idx_ff[IDX_W-1:0];
               rd_idx_in   = rd_idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = INDEX_OUT_W'(chosen_ff);
               rsp_used_in  = USED_OUT_W'(open_ff);
               rsp_err_in   = err_ff;
               rsp_done_in  = last_ff;
               if (last_ff) begin
                  open_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAPACITY_RESET;
         open_ff      <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      weight_ff    <= weight_in;
      last_ff      <= last_in;
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      chosen_ff    <= chosen_in;
      err_ff       <= err_in;
      rsp_index_ff <= rsp_index_in;
      rsp_used_ff  <= rsp_used_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_bin_index       = rsp_index_ff;
   assign rsp_bins_used       = rsp_used_ff;
   assign rsp_placement_error = rsp_err_ff;
   assign rsp_run_done        = rsp_done_ff;

endmodule
